// ----- rtl/core/wps_pkg.sv -----
package wps_pkg;

  localparam int unsigned HostW = 32;
  localparam int unsigned PortW = 16;
  localparam int unsigned MaskW = 16;
  localparam int unsigned EnvW = 4;
  localparam int unsigned ByteW = 8;
  localparam int unsigned MemW = 20;
  localparam int unsigned SlotW = 6;

  localparam logic [MemW-1:0] MinFreeMemReset = 20'd10240;

  typedef enum logic [1:0] {
    OP_UPDATE  = 2'd0,
    OP_REQUEST = 2'd1,
    OP_RELEASE = 2'd2,
    OP_NONE    = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_DONE     = 2'd0,
    ST_NO_WORK  = 2'd1,
    ST_FULL     = 2'd2,
    ST_UNKNOWN  = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN_RD,
    S_SCAN,
    S_PICK,
    S_WRITE,
    S_RESULT
  } state_t;

  typedef struct packed {
    logic [1:0]       opcode;
    logic [HostW-1:0] host_addr;
    logic [PortW-1:0] port;
    logic [MaskW-1:0] env_mask;
    logic [EnvW-1:0]  env_id;
    logic             dedicated;
    logic [ByteW-1:0] processors;
    logic [ByteW-1:0] busy_load;
    logic [ByteW-1:0] task_limit;
    logic [MemW-1:0]  free_memory;
  } req_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [SlotW-1:0] slot;
    logic [HostW-1:0] worker_host;
    logic [PortW-1:0] worker_port;
  } rsp_t;

  typedef struct packed {
    logic [HostW-1:0] host;
    logic [PortW-1:0] port;
    logic [MaskW-1:0] envs;
    logic             dedicated;
    logic [ByteW-1:0] procs;
    logic [ByteW-1:0] load;
    logic [ByteW-1:0] limit;
    logic [MemW-1:0]  memory;
    logic [ByteW-1:0] running;
  } entry_t;

endpackage

// ----- rtl/core/wps_req_if.sv -----
interface wps_req_if;
  logic          valid;
  logic          ready;
  wps_pkg::req_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ----- rtl/core/wps_rsp_if.sv -----
interface wps_rsp_if;
  logic          valid;
  logic          ready;
  wps_pkg::rsp_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ----- rtl/core/wps_cap.sv -----
module wps_cap (
  input  wps_pkg::entry_t               entry,
  input  logic [wps_pkg::MemW-1:0]      min_free_memory,
  output logic [wps_pkg::ByteW-1:0]     capacity
);
  import wps_pkg::*;

  logic [ByteW-1:0] foreign;
  logic [ByteW-1:0] avail;

  always_comb begin
    foreign = (entry.load > entry.running) ? entry.load - entry.running : '0;
    avail = (entry.procs > foreign) ? entry.procs - foreign : '0;
    if (entry.memory < min_free_memory) begin
      capacity = entry.running;
    end else begin
      capacity = (entry.limit < avail) ? entry.limit : avail;
    end
  end
endmodule

// ----- rtl/core/worker_pick_scheduler_core.sv -----
// Worker table and task picker.
// Channels: req (sink) carries update, request and release transactions;
// rsp (source) returns one result transaction per accepted item.
// cfg_we/cfg_data write min_free_memory; write only while idle.
// Each item scans the table one slot per cycle through a single capacity
// unit and two cross-multiply compares reading a one-read one-write memory.
// The result is registered and presented in S_RESULT after the read, scan,
// pick and write-back states; the next item can be accepted only once the
// result has been taken. An unknown opcode skips the scan and goes straight
// to the result state.
// One item is in flight at a time; req.ready is low from acceptance until
// the result is taken.
// Update prefers a match over the lowest free slot; request keeps the best
// dedicated-under-half-load, best other, and first own-host candidates
// in parallel during the single scan, then chooses in that order.
// Reset clears all valid bits and sets min_free_memory to 10240; slot data
// memory is not cleared. If rsp.ready is low the result is held in its
// register and no new transaction is accepted.
module worker_pick_scheduler_core #(
  parameter int unsigned NUM_WORKERS = 64,
  parameter int unsigned NUM_ENVS    = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [wps_pkg::MemW-1:0]  cfg_data,
  wps_req_if.sink                   req,
  wps_rsp_if.source                 rsp
);
  import wps_pkg::*;

  localparam int unsigned IdxW = (NUM_WORKERS > 1) ? $clog2(NUM_WORKERS) : 1;
  localparam int unsigned CntW = $clog2(NUM_WORKERS + 1);

  state_t state, state_next;

  logic [MemW-1:0] min_free_memory;
  entry_t          mem [NUM_WORKERS];
  logic [NUM_WORKERS-1:0] valid;

  req_t            item;
  logic [CntW-1:0] idx;
  logic [IdxW-1:0] rd_idx;
  logic [IdxW-1:0] cur_idx;
  logic [IdxW-1:0] pick_idx;
  entry_t          rd_data;
  logic            cur_ok;

  logic             match_found, free_found;
  logic [IdxW-1:0]  match_idx, free_idx;
  logic             ded_found, any_found, self_found;
  logic [IdxW-1:0]  ded_idx, any_idx, self_idx;
  logic [ByteW-1:0] ded_run, ded_cap, any_run, any_cap;

  logic [ByteW-1:0] cap;
  logic             keep, is_self, ded_ok, env_ok;
  logic             ded_better, any_better;

  logic             wr_en;
  logic [IdxW-1:0]  wr_idx;
  entry_t           wr_data;
  logic             set_valid;
  rsp_t             result, result_next;

  wps_cap u_cap (
    .entry          (rd_data),
    .min_free_memory(min_free_memory),
    .capacity       (cap)
  );

  assign pick_idx = (item.opcode == OP_UPDATE) ?
                    (match_found ? match_idx : free_idx) :
                    (item.opcode == OP_REQUEST) ?
                    (ded_found ? ded_idx : (any_found ? any_idx : self_idx)) :
                    match_idx;

  assign rd_idx = (state == S_PICK) ? pick_idx : idx[IdxW-1:0];

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_idx];
    if (wr_en) begin
      mem[wr_idx] <= wr_data;
    end
  end

  always_comb begin
    env_ok = ({28'd0, item.env_id} < NUM_ENVS) && rd_data.envs[item.env_id];
    keep = cur_ok && env_ok && (rd_data.running < cap);
    is_self = keep && !self_found && (rd_data.host == item.host_addr);
    ded_ok = rd_data.dedicated && ({1'b0, rd_data.running, 1'b0} < {2'b0, rd_data.procs});
    ded_better = !ded_found ||
                 ({8'd0, rd_data.running} * {8'd0, ded_cap} <
                  {8'd0, ded_run} * {8'd0, cap});
    any_better = !any_found ||
                 ({8'd0, rd_data.running} * {8'd0, any_cap} <
                  {8'd0, any_run} * {8'd0, cap});
  end

  always_comb begin
    state_next = state;
    wr_en = 1'b0;
    wr_idx = '0;
    wr_data = rd_data;
    set_valid = 1'b0;
    result_next = result;
    case (state)
      S_IDLE: begin
        if (req.valid) begin
          state_next = (req.payload.opcode == OP_NONE) ? S_RESULT : S_SCAN_RD;
          result_next = '{status: ST_UNKNOWN, slot: '0, worker_host: '0, worker_port: '0};
        end
      end
      S_SCAN_RD: state_next = S_SCAN;
      S_SCAN: begin
        if (idx == CntW'(NUM_WORKERS)) begin
          state_next = S_PICK;
        end
      end
      S_PICK: state_next = S_WRITE;
      S_WRITE: begin
        state_next = S_RESULT;
        result_next = '{status: ST_DONE, slot: '0, worker_host: '0, worker_port: '0};
        case (item.opcode)
          OP_UPDATE: begin
            wr_idx = match_found ? match_idx : free_idx;
            wr_data.host = item.host_addr;
            wr_data.port = item.port;
            wr_data.envs = item.env_mask;
            wr_data.dedicated = item.dedicated;
            wr_data.procs = item.processors;
            wr_data.load = item.busy_load;
            wr_data.limit = item.task_limit;
            wr_data.memory = item.free_memory;
            wr_data.running = match_found ? rd_data.running : '0;
            if (match_found || free_found) begin
              wr_en = 1'b1;
              set_valid = !match_found;
              result_next.slot = SlotW'(wr_idx);
              result_next.worker_host = item.host_addr;
              result_next.worker_port = item.port;
            end else begin
              result_next.status = ST_FULL;
            end
          end
          OP_REQUEST: begin
            wr_idx = ded_found ? ded_idx : (any_found ? any_idx : self_idx);
            if (ded_found || any_found || self_found) begin
              wr_en = 1'b1;
              if (rd_data.running != '1) begin
                wr_data.running = rd_data.running + 1'b1;
              end
              result_next.slot = SlotW'(wr_idx);
              result_next.worker_host = rd_data.host;
              result_next.worker_port = rd_data.port;
            end else begin
              result_next.status = ST_NO_WORK;
            end
          end
          default: begin
            wr_idx = match_idx;
            if (match_found) begin
              wr_en = 1'b1;
              if (rd_data.running != '0) begin
                wr_data.running = rd_data.running - 1'b1;
              end
              result_next.slot = SlotW'(wr_idx);
              result_next.worker_host = rd_data.host;
              result_next.worker_port = rd_data.port;
            end else begin
              result_next.status = ST_UNKNOWN;
            end
          end
        endcase
      end
      S_RESULT: begin
        if (rsp.ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      valid <= '0;
      min_free_memory <= MinFreeMemReset;
      idx <= '0;
    end else begin
      state <= state_next;
      result <= result_next;
      if (cfg_we) begin
        min_free_memory <= cfg_data;
      end
      if (set_valid) begin
        valid[wr_idx] <= 1'b1;
      end
      if (state == S_IDLE && req.valid) begin
        item <= req.payload;
        idx <= '0;
        match_found <= 1'b0;
        free_found <= 1'b0;
        ded_found <= 1'b0;
        any_found <= 1'b0;
        self_found <= 1'b0;
      end
      if (state == S_SCAN_RD) begin
        cur_idx <= rd_idx;
        cur_ok <= valid[rd_idx];
        idx <= idx + 1'b1;
      end
      if (state == S_SCAN) begin
        cur_idx <= rd_idx;
        cur_ok <= (idx < CntW'(NUM_WORKERS)) ? valid[rd_idx] : 1'b0;
        if (idx < CntW'(NUM_WORKERS)) begin
          idx <= idx + 1'b1;
        end
        if (!cur_ok && !free_found) begin
          free_found <= 1'b1;
          free_idx <= cur_idx;
        end
        if (cur_ok && !match_found && rd_data.host == item.host_addr &&
            rd_data.port == item.port) begin
          match_found <= 1'b1;
          match_idx <= cur_idx;
        end
        if (is_self) begin
          self_found <= 1'b1;
          self_idx <= cur_idx;
        end else if (keep) begin
          if (ded_ok && ded_better) begin
            ded_found <= 1'b1;
            ded_idx <= cur_idx;
            ded_run <= rd_data.running;
            ded_cap <= cap;
          end
          if (any_better) begin
            any_found <= 1'b1;
            any_idx <= cur_idx;
            any_run <= rd_data.running;
            any_cap <= cap;
          end
        end
      end
    end
  end

  assign req.ready = (state == S_IDLE);
  assign rsp.valid = (state == S_RESULT);
  assign rsp.payload = result;

`ifndef SYNTHESIS
  a_one_side: assert property (@(posedge clk) disable iff (rst)
    !(req.ready && rsp.valid)) else $error("ready while result pending");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.payload))
    else $error("result dropped");
  a_zero: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.payload.status != ST_DONE |-> rsp.payload.worker_host == '0)
    else $error("nonzero host on failure");
`endif
endmodule

// ----- test/tb.sv -----
`timescale 1ns / 100ps

module tb;
  import wps_pkg::*;

  localparam int NW = 64;
  localparam int WATCHDOG_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [MemW-1:0] cfg_data = '0;

  wps_req_if req_ch();
  wps_rsp_if rsp_ch();

  worker_pick_scheduler_core dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .req(req_ch.sink), .rsp(rsp_ch.source)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  logic [MemW-1:0] min_mem;
  logic            w_valid [NW];
  entry_t          w_tab [NW];
  rsp_t            pending_results [$];
  int              mismatches = 0;
  int              idle_cycles = 0;
  bit              hold_rsp = 1'b0;
  logic [HostW-1:0] hosts [4] = '{32'h0A000001, 32'h0A000002, 32'hFFFFFFFF, 32'h0};
  logic [PortW-1:0] ports [3] = '{16'd8080, 16'hFFFF, 16'd0};

  initial begin
    req_ch.valid = 1'b0;
    req_ch.payload = '0;
    rsp_ch.ready = 1'b0;
  end

  function automatic logic [8:0] capacity(int i);
    logic [8:0] run, foreign, avail;
    run = w_tab[i].running;
    if (w_tab[i].memory < min_mem) return run;
    foreign = (w_tab[i].load > run) ? w_tab[i].load - run : 9'd0;
    avail = (w_tab[i].procs > foreign) ? w_tab[i].procs - foreign : 9'd0;
    return (w_tab[i].limit < avail) ? w_tab[i].limit : avail;
  endfunction

  function automatic int locate(logic [HostW-1:0] h, logic [PortW-1:0] p);
    for (int i = 0; i < NW; i++)
      if (w_valid[i] && w_tab[i].host == h && w_tab[i].port == p) return i;
    return -1;
  endfunction

  function automatic int least_utilized(bit kept [NW], bit ded_only);
    int best;
    logic [17:0] best_run, best_cap, run, cap;
    best = -1; best_run = 0; best_cap = 1;
    for (int i = 0; i < NW; i++) begin
      if (!kept[i]) continue;
      if (ded_only && !(w_tab[i].dedicated && ({1'b0, w_tab[i].running} << 1) < w_tab[i].procs))
        continue;
      run = w_tab[i].running;
      cap = capacity(i);
      if (best < 0 || run * best_cap < best_run * cap) begin
        best = i; best_run = run; best_cap = cap;
      end
    end
    return best;
  endfunction

  function automatic rsp_t schedule(req_t r);
    rsp_t o;
    int s, own;
    bit kept [NW];
    o = '0; s = -1; own = -1;
    case (opcode_t'(r.opcode))
      OP_UPDATE: begin
        s = locate(r.host_addr, r.port);
        if (s < 0)
          for (int i = 0; i < NW; i++)
            if (!w_valid[i]) begin
              s = i; w_valid[i] = 1'b1; w_tab[i].running = '0; break;
            end
        if (s < 0) o.status = ST_FULL;
        else begin
          w_tab[s].host = r.host_addr; w_tab[s].port = r.port;
          w_tab[s].envs = r.env_mask; w_tab[s].dedicated = r.dedicated;
          w_tab[s].procs = r.processors; w_tab[s].load = r.busy_load;
          w_tab[s].limit = r.task_limit; w_tab[s].memory = r.free_memory;
        end
      end
      OP_REQUEST: begin
        for (int i = 0; i < NW; i++) begin
          kept[i] = 1'b0;
          if (!w_valid[i] || !w_tab[i].envs[r.env_id]) continue;
          if ({1'b0, w_tab[i].running} >= capacity(i)) continue;
          if (own < 0 && w_tab[i].host == r.host_addr) begin
            own = i; continue;
          end
          kept[i] = 1'b1;
        end
        s = least_utilized(kept, 1'b1);
        if (s < 0) s = least_utilized(kept, 1'b0);
        if (s < 0) s = own;
        if (s < 0) o.status = ST_NO_WORK;
        else if (w_tab[s].running != 8'hFF) w_tab[s].running++;
      end
      OP_RELEASE: begin
        s = locate(r.host_addr, r.port);
        if (s < 0) o.status = ST_UNKNOWN;
        else if (w_tab[s].running != 0) w_tab[s].running--;
      end
      default: o.status = ST_UNKNOWN;
    endcase
    if (o.status == ST_DONE) begin
      o.slot = s[SlotW-1:0]; o.worker_host = w_tab[s].host; o.worker_port = w_tab[s].port;
    end
    return o;
  endfunction

  function automatic int gap_len();
    int k;
    k = $urandom_range(0, 99);
    if (k < 50) return 0;
    if (k < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  task automatic send_item(req_t r);
    repeat (gap_len() + 1) @(negedge clk);
    req_ch.payload <= r;
    req_ch.valid <= 1'b1;
    do @(posedge clk); while (!req_ch.ready);
    pending_results = {pending_results, schedule(r)};
    @(negedge clk);
    req_ch.valid <= 1'b0;
  endtask

  always @(negedge clk) begin
    if (rst || hold_rsp) rsp_ch.ready <= 1'b0;
    else rsp_ch.ready <= ($urandom_range(0, 9) < 7);
  end

  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", rsp_ch.payload);
      end else begin
        rsp_t e;
        e = pending_results.pop_front();
        if (rsp_ch.payload.status !== e.status || rsp_ch.payload.slot !== e.slot ||
            rsp_ch.payload.worker_host !== e.worker_host ||
            rsp_ch.payload.worker_port !== e.worker_port) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p, got %p", e, rsp_ch.payload);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic req_t rand_update(bit full_range);
    req_t r;
    r = '0;
    r.opcode = OP_UPDATE;
    r.host_addr = full_range ? $urandom() : hosts[$urandom_range(0, 3)];
    r.port = PortW'(full_range ? $urandom() :
                    ports[$urandom_range(0, 2)] + $urandom_range(0, 30));
    r.env_mask = ($urandom_range(0, 3) == 0) ? MaskW'($urandom()) :
                 (16'h1 << $urandom_range(0, 3));
    r.dedicated = 1'($urandom());
    r.processors = ByteW'(($urandom_range(0, 5) == 0) ? $urandom() : $urandom_range(1, 16));
    r.busy_load = ByteW'(($urandom_range(0, 5) == 0) ? $urandom() : $urandom_range(0, 16));
    r.task_limit = ByteW'(($urandom_range(0, 5) == 0) ? $urandom() : $urandom_range(0, 20));
    r.free_memory = MemW'($urandom());
    r.env_id = EnvW'($urandom());
    return r;
  endfunction

  function automatic req_t rand_item();
    req_t r;
    int k;
    k = $urandom_range(0, 99);
    r = rand_update(k < 5);
    if (k >= 30 && k < 75) begin
      r.opcode = OP_REQUEST;
      r.env_id = EnvW'(($urandom_range(0, 4) == 0) ? $urandom() : $urandom_range(0, 3));
    end else if (k >= 75 && k < 97) r.opcode = OP_RELEASE;
    else if (k >= 97) r.opcode = OP_NONE;
    return r;
  endfunction

  task automatic drain();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (NW + 10) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_min_mem(logic [MemW-1:0] v);
    drain();
    cfg_data <= v;
    cfg_we <= 1'b1;
    @(negedge clk);
    cfg_we <= 1'b0;
    min_mem = v;
  endtask

  task automatic test_directed();
    req_t r;
    r = '0;
    r.opcode = OP_REQUEST;
    send_item(r);
    r.opcode = OP_RELEASE;
    send_item(r);
    r.opcode = OP_NONE;
    r.host_addr = '1;
    send_item(r);
    r = '0;
    r.opcode = OP_UPDATE; r.host_addr = '1; r.port = '1; r.env_mask = '1;
    r.dedicated = 1'b1; r.processors = '1; r.busy_load = '1; r.task_limit = '1;
    r.free_memory = '1;
    send_item(r);
    r.opcode = OP_REQUEST; r.env_id = 4'hF;
    send_item(r);
    r.host_addr = 32'h1;
    for (int i = 0; i < 3; i++) send_item(r);
    r.opcode = OP_UPDATE; r.host_addr = 32'h5; r.port = 16'h0; r.dedicated = 1'b0;
    r.processors = 8'd4; r.busy_load = 8'd0; r.task_limit = 8'd1; r.free_memory = 20'd0;
    send_item(r);
    r.opcode = OP_REQUEST; r.host_addr = 32'h5; r.env_id = 4'h0;
    send_item(r);
    r.opcode = OP_RELEASE; r.host_addr = '1; r.port = '1;
    for (int i = 0; i < 2; i++) send_item(r);
    r.port = 16'h1234;
    send_item(r);
    write_min_mem('0);
    r.opcode = OP_REQUEST; r.host_addr = 32'h5; r.env_id = 4'h0;
    for (int i = 0; i < 2; i++) send_item(r);
  endtask

  task automatic test_table_full();
    req_t r;
    for (int i = 0; i < NW + 2; i++) begin
      r = rand_update(1'b1);
      r.host_addr = 32'hC0A80000 + i;
      send_item(r);
    end
    for (int i = 0; i < NW; i++) begin
      r = '0;
      r.opcode = OP_RELEASE; r.host_addr = 32'hC0A80000 + i; r.port = 16'h0;
      send_item(r);
    end
  endtask

  task automatic test_backpressure();
    hold_rsp = 1'b1;
    fork
      begin
        repeat (600) @(posedge clk);
        hold_rsp = 1'b0;
      end
      for (int i = 0; i < 6; i++) send_item(rand_item());
    join
    drain();
  endtask

  task automatic test_random(int n);
    for (int i = 0; i < n; i++) send_item(rand_item());
  endtask

  initial begin
    min_mem = MinFreeMemReset;
    for (int i = 0; i < NW; i++) begin
      w_valid[i] = 1'b0;
      w_tab[i] = '0;
    end
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_backpressure();
    test_random(300);
    write_min_mem('1);
    test_random(200);
    write_min_mem(20'd10240);
    test_random(300);
    write_min_mem(20'd300000);
    test_table_full();
    test_random(300);
    write_min_mem(20'd5000);
    test_random(300);
    drain();
    if (mismatches == 0 && pending_results.size() == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end
endmodule

// ----- files.f -----
rtl/core/wps_pkg.sv
rtl/core/wps_req_if.sv
rtl/core/wps_rsp_if.sv
rtl/core/wps_cap.sv
rtl/core/worker_pick_scheduler_core.sv
test/tb.sv
